// ===== rtl/core/icon_dib_row_to_bgra_unpacker_defines.svh =====
// ---------------------------------------------------------------------------
// icon dib row unpacker assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ---------------------------------------------------------------------------
`ifndef ICON_DIB_ROW_TO_BGRA_UNPACKER_DEFINES_SVH
`define ICON_DIB_ROW_TO_BGRA_UNPACKER_DEFINES_SVH

// same-cycle implication
`define IDBU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IDBU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/idbu_pkg.sv =====
// ---------------------------------------------------------------------------
// idbu_pkg
// shared constants, codes and beat structs of the icon dib row unpacker
// ---------------------------------------------------------------------------
`default_nettype none

package idbu_pkg;

   localparam int DEF_MAX_ROW_WIDTH = 256;
   localparam int DEF_PALETTE_DEPTH = 256;

   // depth_mode codes
   localparam logic [2:0] DEPTH_1BPP  = 3'd0;
   localparam logic [2:0] DEPTH_4BPP  = 3'd1;
   localparam logic [2:0] DEPTH_8BPP  = 3'd2;
   localparam logic [2:0] DEPTH_24BPP = 3'd3;
   localparam logic [2:0] DEPTH_32BPP = 3'd4;

   // register indexes
   localparam int         CSR_IDX_W      = 2;
   localparam logic [1:0] CSR_DEPTH_MODE = 2'd0;
   localparam logic [1:0] CSR_ROW_WIDTH  = 2'd1;

   localparam logic [2:0] RESET_DEPTH_MODE = DEPTH_8BPP;
   localparam logic [8:0] RESET_ROW_WIDTH  = 9'd32;

   // request kinds
   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_COLOR   = 1'b1;

   localparam logic [7:0]  ALPHA_FF     = 8'hFF;
   localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
   localparam logic [31:0] PIX_WHITE    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        rd_en;
      logic [7:0]  rd_addr;
      logic        wr_en;
      logic [7:0]  wr_addr;
      logic [23:0] wr_data;
   } pal_port_type;

   typedef struct packed {
      logic [31:0] pix;
      logic        use_pal;
      logic        pal_hit;
      logic        clear;
      logic [7:0]  column;
      logic        row_end;
      logic        last;
   } pix_beat_type;

endpackage

`default_nettype wire

// ===== rtl/core/idbu_palette_ram.sv =====
// ---------------------------------------------------------------------------
// idbu_palette_ram
// palette store, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module idbu_palette_ram #(
   parameter int PALETTE_DEPTH = idbu_pkg::DEF_PALETTE_DEPTH
) (
   input  wire                   clock,
   input  idbu_pkg::pal_port_type pal,
   output logic [23:0]           rd_data
);
   import idbu_pkg::*;

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [23:0] mem [PALETTE_DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (pal.wr_en) begin
         mem[pal.wr_addr[AW-1:0]] <= pal.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pal.rd_en) begin
         rd_data_ff <= mem[pal.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/idbu_slot_seq.sv =====
// ---------------------------------------------------------------------------
// idbu_slot_seq
// holds one request and walks its pixel slots, one per cycle unless a beat is held; owns the
// row position, 24 bpp byte carry and configuration registers
// ---------------------------------------------------------------------------
`default_nettype none

module idbu_slot_seq #(
   parameter int MAX_ROW_WIDTH = idbu_pkg::DEF_MAX_ROW_WIDTH,
   parameter int PALETTE_DEPTH = idbu_pkg::DEF_PALETTE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_type,
   input  wire  [7:0]                   req_palette_index,
   input  wire  [23:0]                  req_palette_color,
   input  wire  [31:0]                  req_color_word,
   input  wire  [31:0]                  req_mask_bits,
   input  wire                          csr_wr_en,
   input  wire  [idbu_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [8:0]                   csr_wdata,
   input  wire                          beat_ready,
   output logic                         beat_vld,
   output idbu_pkg::pix_beat_type        beat,
   output idbu_pkg::pal_port_type        pal,
   output logic                         busy
);
   import idbu_pkg::*;

   localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
   localparam int MAXW_W = $clog2(MAX_ROW_WIDTH + 1);
   localparam int CMP_W  = ((MAXW_W > 9) ? MAXW_W : 9) + 1;
   localparam logic [CMP_W-1:0] MAX_W     = CMP_W'(MAX_ROW_WIDTH);
   localparam logic [8:0]       PAL_LIMIT = 9'(PALETTE_DEPTH);

   logic              item_vld_ff, item_vld_in;
   logic              item_type_ff;
   logic [31:0]       word_ff;
   logic [31:0]       mask_ff;
   logic [7:0]        pidx_ff;
   logic [23:0]       pcolor_ff;
   logic [4:0]        slot_ff, slot_in;
   logic [1:0]        emit_k_ff, emit_k_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [15:0]       carry_ff, carry_in;
   logic [1:0]        ccnt_ff, ccnt_in;
   logic [2:0]        depth_ff, depth_in;
   logic [8:0]        rwidth_ff, rwidth_in;

   logic [CMP_W-1:0]  rw_ext, eff_w, col_ext, col_next_ext;
   logic              at_end;
   logic [7:0]        byte8;
   logic [1:0]        cnt_eff;
   logic [15:0]       acc_eff;
   logic              emit, is_pal, last_slot, final_emit, defined;
   logic [7:0]        pix_idx;
   logic [31:0]       pix_raw;
   logic [4:0]        k;
   logic [15:0]       slot_carry;
   logic [1:0]        slot_ccnt;
   logic              color_item, pal_item, go, done, finish, accept, csr_hit;

   // effective row width and row end test
   always_comb begin
      rw_ext = CMP_W'(rwidth_ff);
      if (rwidth_ff == 9'd0) begin
         eff_w = CMP_W'(1);
      end else if (rw_ext > MAX_W) begin
         eff_w = MAX_W;
      end else begin
         eff_w = rw_ext;
      end
      col_ext      = CMP_W'(col_ff);
      col_next_ext = col_ext + CMP_W'(1);
      at_end       = (col_next_ext >= eff_w);
   end

   assign byte8   = word_ff[{slot_ff[1:0], 3'b000} +: 8];
   assign cnt_eff = (ccnt_ff == 2'd3) ? 2'd0 : ccnt_ff;
   assign acc_eff = (ccnt_ff == 2'd3) ? 16'd0 : carry_ff;

   // slot decode
   always_comb begin
      emit       = 1'b0;
      is_pal     = 1'b0;
      pix_idx    = 8'd0;
      pix_raw    = ALPHA_OPAQUE;
      k          = slot_ff;
      last_slot  = 1'b1;
      final_emit = 1'b1;
      defined    = 1'b1;
      slot_carry = carry_ff;
      slot_ccnt  = ccnt_ff;
      case (depth_ff)
         DEPTH_1BPP: begin
            emit       = 1'b1;
            pix_raw    = word_ff[{slot_ff[4:3], ~slot_ff[2:0]}] ? PIX_WHITE : ALPHA_OPAQUE;
            last_slot  = (slot_ff == 5'd31);
            final_emit = last_slot;
         end
         DEPTH_4BPP: begin
            emit       = 1'b1;
            is_pal     = 1'b1;
            pix_idx    = {4'd0, word_ff[{slot_ff[2:1], ~slot_ff[0], 2'b00} +: 4]};
            last_slot  = (slot_ff == 5'd7);
            final_emit = last_slot;
         end
         DEPTH_8BPP: begin
            emit       = 1'b1;
            is_pal     = 1'b1;
            pix_idx    = byte8;
            last_slot  = (slot_ff == 5'd3);
            final_emit = last_slot;
         end
         DEPTH_24BPP: begin
            last_slot  = (slot_ff == 5'd3);
            k          = {3'b000, emit_k_ff};
            // an emission past the first byte slot is the word's final one
            final_emit = (slot_ff != 5'd0);
            if (cnt_eff == 2'd2) begin
               emit       = 1'b1;
               pix_raw    = {ALPHA_FF, byte8, acc_eff};
               slot_carry = 16'd0;
               slot_ccnt  = 2'd0;
            end else if (cnt_eff == 2'd1) begin
               slot_carry = {byte8, acc_eff[7:0]};
               slot_ccnt  = 2'd2;
            end else begin
               slot_carry = {8'd0, byte8};
               slot_ccnt  = 2'd1;
            end
         end
         DEPTH_32BPP: begin
            emit    = 1'b1;
            pix_raw = word_ff;
            k       = 5'd0;
         end
         default: begin
            defined = 1'b0;
         end
      endcase
   end

   // slot advance control
   always_comb begin
      color_item = item_vld_ff && (item_type_ff == REQ_COLOR) && defined;
      pal_item   = item_vld_ff && (item_type_ff == REQ_PALETTE);
      go         = item_vld_ff && (!(color_item && emit) || beat_ready);
      done       = !color_item || last_slot || (emit && at_end);
      finish     = go && done;
      req_stall  = item_vld_ff && !finish;
      accept     = req_valid && !req_stall;
      csr_hit    = csr_wr_en && ((csr_index == CSR_DEPTH_MODE) ||
                                 (csr_index == CSR_ROW_WIDTH));
   end

   // next state
   always_comb begin
      item_vld_in = item_vld_ff;
      slot_in     = slot_ff;
      emit_k_in   = emit_k_ff;
      col_in      = col_ff;
      carry_in    = carry_ff;
      ccnt_in     = ccnt_ff;
      depth_in    = depth_ff;
      rwidth_in   = rwidth_ff;

      if (finish) begin
         item_vld_in = 1'b0;
      end
      if (accept) begin
         item_vld_in = 1'b1;
         slot_in     = 5'd0;
         emit_k_in   = 2'd0;
      end else if (color_item && go) begin
         slot_in = slot_ff + 5'd1;
         if (emit) begin
            emit_k_in = emit_k_ff + 2'd1;
         end
      end

      if (color_item && go) begin
         if (emit && at_end) begin
            col_in   = '0;
            carry_in = 16'd0;
            ccnt_in  = 2'd0;
         end else begin
            if (emit) begin
               col_in = COL_W'(col_next_ext);
            end
            carry_in = slot_carry;
            ccnt_in  = slot_ccnt;
         end
      end

      if (csr_wr_en && (csr_index == CSR_DEPTH_MODE)) begin
         depth_in = csr_wdata[2:0];
      end
      if (csr_wr_en && (csr_index == CSR_ROW_WIDTH)) begin
         rwidth_in = csr_wdata;
      end
      if (csr_hit) begin
         col_in   = '0;
         carry_in = 16'd0;
         ccnt_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         slot_ff     <= 5'd0;
         emit_k_ff   <= 2'd0;
         col_ff      <= '0;
         carry_ff    <= 16'd0;
         ccnt_ff     <= 2'd0;
         depth_ff    <= RESET_DEPTH_MODE;
         rwidth_ff   <= RESET_ROW_WIDTH;
      end else begin
         item_vld_ff <= item_vld_in;
         slot_ff     <= slot_in;
         emit_k_ff   <= emit_k_in;
         col_ff      <= col_in;
         carry_ff    <= carry_in;
         ccnt_ff     <= ccnt_in;
         depth_ff    <= depth_in;
         rwidth_ff   <= rwidth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_type_ff <= req_type;
         word_ff      <= req_color_word;
         mask_ff      <= req_mask_bits;
         pidx_ff      <= req_palette_index;
         pcolor_ff    <= req_palette_color;
      end
   end

   // beat toward the palette read stage
   always_comb begin
      beat_vld     = color_item && emit;
      beat.pix     = pix_raw;
      beat.use_pal = is_pal;
      beat.pal_hit = ({1'b0, pix_idx} < PAL_LIMIT);
      beat.clear   = mask_ff[k];
      beat.column  = col_ext[7:0];
      beat.row_end = at_end;
      beat.last    = at_end || final_emit;

      pal.rd_en   = beat_vld && beat_ready && is_pal && beat.pal_hit;
      pal.rd_addr = pix_idx;
      pal.wr_en   = pal_item && ({1'b0, pidx_ff} < PAL_LIMIT);
      pal.wr_addr = pidx_ff;
      pal.wr_data = pcolor_ff;
   end

   assign busy = item_vld_ff;

endmodule

`default_nettype wire

// ===== rtl/core/idbu_pixel_out.sv =====
// ---------------------------------------------------------------------------
// idbu_pixel_out
// lines a beat up with its palette read, forms the pixel, output register
// ---------------------------------------------------------------------------
`default_nettype none

module idbu_pixel_out (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   beat_vld,
   input  idbu_pkg::pix_beat_type beat,
   output logic                  beat_ready,
   input  wire  [23:0]           rd_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [31:0]           rsp_pixel_bgra,
   output logic [7:0]            rsp_column,
   output logic                  rsp_row_end,
   output logic                  rsp_last
);
   import idbu_pkg::*;

   logic         s2_vld_ff, s2_vld_in;
   pix_beat_type s2_beat_ff;
   logic         rsp_vld_ff, rsp_vld_in;
   logic [31:0]  pix_ff, pix_in;
   logic [7:0]   col_ff;
   logic         row_end_ff;
   logic         last_ff;
   logic         rsp_ready;

   always_comb begin
      rsp_ready  = !rsp_vld_ff || !rsp_stall;
      beat_ready = !s2_vld_ff || rsp_ready;
      s2_vld_in  = beat_ready ? beat_vld : s2_vld_ff;
      rsp_vld_in = rsp_ready ? s2_vld_ff : rsp_vld_ff;

      if (s2_beat_ff.clear) begin
         pix_in = 32'd0;
      end else if (s2_beat_ff.use_pal) begin
         pix_in = s2_beat_ff.pal_hit ? {ALPHA_FF, rd_data} : ALPHA_OPAQUE;
      end else begin
         pix_in = s2_beat_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_ready && beat_vld) begin
         s2_beat_ff <= beat;
      end
      if (rsp_ready && s2_vld_ff) begin
         pix_ff     <= pix_in;
         col_ff     <= s2_beat_ff.column;
         row_end_ff <= s2_beat_ff.row_end;
         last_ff    <= s2_beat_ff.last;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_pixel_bgra = pix_ff;
   assign rsp_column     = col_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/icon_dib_row_to_bgra_unpacker.sv =====
// Icon DIB row unpacker: takes one little-endian 32-bit word of a 4-byte
// padded DIB row per req beat (or a palette entry write) and gives BGRA
// pixels on rsp, at most one pixel per cycle while rsp is not stalled. A
// color word walks one pixel slot at a time: 32 slots at 1 bpp, 8 at 4 bpp,
// 4 at 8 bpp, 4 at 24 bpp (one byte per slot, carried bytes crossing words),
// 1 at 32 bpp, and it stops early at the row end, where the padding slots
// are dropped. A palette write or a word under an undefined depth gives no
// pixel. The slot walker emits at most one pixel a cycle, which sets the
// rate; the next word is taken in the cycle its last slot goes out. A pixel
// goes to rsp through the palette read stage, then the output register.
// Writing either register restarts the row. The palette comes up
// unknown after reset and must be loaded before 4 or 8 bpp data is sent.
// ---------------------------------------------------------------------------
// icon_dib_row_to_bgra_unpacker
// top level: slot walker, palette memory and pixel output stage
// ---------------------------------------------------------------------------
`default_nettype none

`include "icon_dib_row_to_bgra_unpacker_defines.svh"

module icon_dib_row_to_bgra_unpacker #(
   parameter int MAX_ROW_WIDTH = idbu_pkg::DEF_MAX_ROW_WIDTH,
   parameter int PALETTE_DEPTH = idbu_pkg::DEF_PALETTE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_type,
   input  wire  [7:0]                   req_palette_index,
   input  wire  [23:0]                  req_palette_color,
   input  wire  [31:0]                  req_color_word,
   input  wire  [31:0]                  req_mask_bits,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [31:0]                  rsp_pixel_bgra,
   output logic [7:0]                   rsp_column,
   output logic                         rsp_row_end,
   output logic                         rsp_last,
   // register writes
   input  wire                          csr_wr_en,
   input  wire  [idbu_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [8:0]                   csr_wdata
);
   import idbu_pkg::*;

   logic         beat_vld;
   logic         beat_ready;
   pix_beat_type beat;
   pal_port_type pal;
   logic [23:0]  pal_rd_data;
   logic         seq_busy;

   // slot walker: one pixel slot per cycle unless a beat is held, row and carry state
   idbu_slot_seq #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .req_color_word    (req_color_word),
      .req_mask_bits     (req_mask_bits),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .beat_ready        (beat_ready),
      .beat_vld          (beat_vld),
      .beat              (beat),
      .pal               (pal),
      .busy              (seq_busy)
   );

   // palette: writes come in request order from the walker, so a read
   // always sees every earlier write and never a later one
   idbu_palette_ram #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_pal (
      .clock   (clock),
      .pal     (pal),
      .rd_data (pal_rd_data)
   );

   // palette data lines up with its beat here, then the output register
   idbu_pixel_out u_out (
      .clock          (clock),
      .reset          (reset),
      .beat_vld       (beat_vld),
      .beat           (beat),
      .beat_ready     (beat_ready),
      .rd_data        (pal_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_bgra (rsp_pixel_bgra),
      .rsp_column     (rsp_column),
      .rsp_row_end    (rsp_row_end),
      .rsp_last       (rsp_last)
   );

   // the walker never reads and writes the palette in one cycle
   `IDBU_ASSERT_IMP(a_pal_rw_excl, pal.rd_en, !pal.wr_en, "palette read and write together")
   // a held read stage must keep its palette data: no new read then
   `IDBU_ASSERT_IMP(a_no_read_held, !beat_ready, !pal.rd_en, "palette read while stage held")
   // an accepted beat is in the walker on the next cycle
   `IDBU_ASSERT_NEXT(a_accept_loads, req_valid && !req_stall, seq_busy, "accepted beat lost")

endmodule

`default_nettype wire
